@@ hw/rtl/priority_insert_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the priority insert queue.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message. Checks are switched off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_INSERT_QUEUE_ASSERT_SVH
`define PRIORITY_INSERT_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/piq_pkg.sv @@
// ----------------------------------------------------------------------------
// piq_pkg
// Types, codes and default sizes shared by the priority insert queue.
// ----------------------------------------------------------------------------
package piq_pkg;

  // Default sizes, used as parameter defaults on the top level.
  localparam int PIQ_DEPTH        = 16;
  localparam int PIQ_PAYLOAD_BITS = 64;

  // Request codes carried in the func field.
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_PRIO   = 2'd1;
  localparam logic [1:0] FUNC_POP    = 2'd2;

  // A priority insert with this priority goes straight to the head.
  localparam logic [7:0] PRIO_HEAD = 8'd1;

  // Input word.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] entry_payload;
    logic [7:0]  entry_prio;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [63:0] head_payload;
    logic [7:0]  head_prio;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        is_full;
    logic        dropped;
  } out_word_t;

  // Operation broadcast to every cell in the same cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_HEAD,
    OP_SEARCH,
    OP_POP
  } op_t;

  // Control broadcast from the top level to the cells.
  typedef struct packed {
    op_t        op;
    logic [7:0] prio;
  } cell_ctl_t;

  // Signals rippling from each cell to its right-hand neighbour.
  typedef struct packed {
    logic seen;  // an earlier slot already matched the search
    logic ins;   // the new entry lands in an earlier slot
  } chain_t;

endpackage

@@ hw/rtl/piq_cell.sv @@
// ----------------------------------------------------------------------------
// piq_cell
// One queue slot. Holds a payload and a priority, takes part in the search
// for the insertion point and moves its entry left or right with the queue.
// ----------------------------------------------------------------------------
module piq_cell #(
  parameter int INDEX        = 0,
  parameter int PAYLOAD_BITS = 64,
  parameter int CNT_W        = 5
) (
  input  logic                    clk,
  input  piq_pkg::cell_ctl_t      ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  piq_pkg::chain_t         chain_in,
  output piq_pkg::chain_t         chain_out,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [7:0]              left_prio,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  input  logic [7:0]              right_prio,
  output logic [PAYLOAD_BITS-1:0] payload_q,
  output logic [7:0]              prio_q,
  output logic [PAYLOAD_BITS-1:0] payload_nxt,
  output logic [7:0]              prio_nxt
);

  import piq_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic [PAYLOAD_BITS-1:0] payload_r;
  logic [7:0]              prio_r;
  logic                    is_tail;
  logic                    match;
  logic                    ins_here;

  // Local view of the slot: first free slot, and a search hit past the head.
  assign is_tail = (count == IDX);
  assign match   = (INDEX != 0) && (IDX < count) && (prio_r >= ctl.prio);

  // Decide whether the new entry is written into this slot.
  always_comb begin
    unique case (ctl.op)
      OP_APPEND: ins_here = is_tail;
      OP_HEAD:   ins_here = (INDEX == 0);
      OP_SEARCH: ins_here = (match || is_tail) && !chain_in.seen;
      default:   ins_here = 1'b0;
    endcase
  end

  // Pass the search and insertion state on to the next slot.
  assign chain_out.seen = chain_in.seen | match;
  assign chain_out.ins  = chain_in.ins | ins_here;

  // Next contents: shift in from the right on a removal, take the new entry,
  // shift in from the left behind an insertion, or hold.
  always_comb begin
    if (ctl.op == OP_POP) begin
      payload_nxt = right_payload;
      prio_nxt    = right_prio;
    end else if (ins_here) begin
      payload_nxt = new_payload;
      prio_nxt    = ctl.prio;
    end else if (chain_in.ins) begin
      payload_nxt = left_payload;
      prio_nxt    = left_prio;
    end else begin
      payload_nxt = payload_r;
      prio_nxt    = prio_r;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
    prio_r    <= prio_nxt;
  end

  assign payload_q = payload_r;
  assign prio_q    = prio_r;

endmodule

@@ hw/rtl/priority_insert_queue.sv @@
// ----------------------------------------------------------------------------
// priority_insert_queue
// Bounded queue of payload and priority entries held in a chain of slots.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one request word:
//   append at the tail, insert by priority, or remove the head. Each accepted
//   word gives exactly one result word on the output channel (out_valid,
//   out_stall, out_data) with the head entry, the count and the flags.
//   A result is presented in the cycle after its request is accepted and is
//   held in an output register. A new request is accepted in the same cycle
//   as the previous result is taken, so the queue sustains one word per
//   cycle unless the receiver stalls. All slots decide their move in the
//   same cycle; the insertion point is found by a compare chain that ripples
//   through the slots. While the receiver stalls a waiting result, in_stall
//   is raised and the slots hold their contents.
//   Reset clears the entry count and the result valid flag; slot contents
//   are left as they are and are never read until written again.
// ----------------------------------------------------------------------------
`include "priority_insert_queue_assert.svh"

module priority_insert_queue #(
  parameter int DEPTH        = piq_pkg::PIQ_DEPTH,
  parameter int PAYLOAD_BITS = piq_pkg::PIQ_PAYLOAD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  piq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output piq_pkg::out_word_t out_data
);

  import piq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_word_t               out_data_r;
  out_word_t               out_data_nxt;
  logic                    accept;
  logic                    full;
  logic                    is_enq;
  logic [CMP_W-1:0]        n_ext;
  logic [CMP_W-1:0]        p_ext;
  cell_ctl_t               ctl;
  logic [PAYLOAD_BITS-1:0] new_payload;
  logic [PAYLOAD_BITS-1:0] head_payload_nxt;
  logic [7:0]              head_prio_nxt;
  chain_t                  chain [DEPTH+1];
  logic [PAYLOAD_BITS-1:0] slot_payload [DEPTH];
  logic [7:0]              slot_prio [DEPTH];

  // Handshake: take a word unless a result is still waiting and stalled.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign full        = (count_r == FULL_COUNT);
  assign is_enq      = (in_data.func == FUNC_APPEND) || (in_data.func == FUNC_PRIO);
  assign n_ext       = CMP_W'(count_r);
  assign p_ext       = CMP_W'(in_data.entry_prio);
  assign new_payload = in_data.entry_payload[PAYLOAD_BITS-1:0];

  // Decode the request into the operation broadcast to all slots.
  always_comb begin
    ctl.prio = in_data.entry_prio;
    ctl.op   = OP_HOLD;
    if (accept) begin
      if (in_data.func == FUNC_APPEND && !full) begin
        ctl.op = OP_APPEND;
      end else if (in_data.func == FUNC_PRIO && !full) begin
        if (count_r == '0) begin
          ctl.op = OP_HEAD;
        end else if (n_ext < p_ext) begin
          ctl.op = OP_APPEND;
        end else if (in_data.entry_prio == PRIO_HEAD) begin
          ctl.op = OP_HEAD;
        end else begin
          ctl.op = OP_SEARCH;
        end
      end else if (in_data.func == FUNC_POP && count_r != '0) begin
        ctl.op = OP_POP;
      end
    end
  end

  // Entry count follows the operation.
  always_comb begin
    case (ctl.op)
      OP_APPEND, OP_HEAD, OP_SEARCH: count_nxt = count_r + 1'b1;
      OP_POP:                        count_nxt = count_r - 1'b1;
      default:                       count_nxt = count_r;
    endcase
  end

  // The chain of slots.
  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PAYLOAD_BITS-1:0] left_payload;
    logic [7:0]              left_prio;
    logic [PAYLOAD_BITS-1:0] right_payload;
    logic [7:0]              right_prio;

    if (i == 0) begin : g_first
      assign left_payload = '0;
      assign left_prio    = '0;
    end else begin : g_inner_left
      assign left_payload = slot_payload[i-1];
      assign left_prio    = slot_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_payload = slot_payload[i];
      assign right_prio    = slot_prio[i];
    end else begin : g_inner_right
      assign right_payload = slot_payload[i+1];
      assign right_prio    = slot_prio[i+1];
    end

    if (i == 0) begin : g_head
      piq_cell #(
        .INDEX        (i),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .CNT_W        (CNT_W)
      ) u_cell (
        .clk           (clk),
        .ctl           (ctl),
        .count         (count_r),
        .new_payload   (new_payload),
        .chain_in      (chain[i]),
        .chain_out     (chain[i+1]),
        .left_payload  (left_payload),
        .left_prio     (left_prio),
        .right_payload (right_payload),
        .right_prio    (right_prio),
        .payload_q     (slot_payload[i]),
        .prio_q        (slot_prio[i]),
        .payload_nxt   (head_payload_nxt),
        .prio_nxt      (head_prio_nxt)
      );
    end else begin : g_body
      piq_cell #(
        .INDEX        (i),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .CNT_W        (CNT_W)
      ) u_cell (
        .clk           (clk),
        .ctl           (ctl),
        .count         (count_r),
        .new_payload   (new_payload),
        .chain_in      (chain[i]),
        .chain_out     (chain[i+1]),
        .left_payload  (left_payload),
        .left_prio     (left_prio),
        .right_payload (right_payload),
        .right_prio    (right_prio),
        .payload_q     (slot_payload[i]),
        .prio_q        (slot_prio[i]),
        .payload_nxt   (),
        .prio_nxt      ()
      );
    end
  end

  // Build the result word from the state after the operation.
  always_comb begin
    out_data_nxt.head_payload = (count_nxt == '0) ? 64'd0 : 64'(head_payload_nxt);
    out_data_nxt.head_prio    = (count_nxt == '0) ? 8'd0 : head_prio_nxt;
    out_data_nxt.entry_count  = 5'(count_nxt);
    out_data_nxt.is_empty     = (count_nxt == '0);
    out_data_nxt.is_full      = (count_nxt == FULL_COUNT);
    out_data_nxt.dropped      = is_enq && full;
  end

  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register, loaded with each accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the queue's own bookkeeping.
  `PIQ_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_r <= FULL_COUNT, "count beyond depth")
  `PIQ_ASSERT_NEXT(a_pop_count, clk, rst_n, accept && in_data.func == FUNC_POP && count_r != '0, count_r == $past(count_r) - 1'b1, "removal did not lower the count")
  `PIQ_ASSERT_IMPLY(a_drop_full, clk, rst_n, out_valid_r && out_data_r.dropped, out_data_r.is_full && !out_data_r.is_empty, "drop reported on a queue that is not full")
  `PIQ_ASSERT_IMPLY(a_empty_head, clk, rst_n, out_valid_r && out_data_r.is_empty, out_data_r.head_prio == 8'd0 && out_data_r.head_payload == 64'd0 && out_data_r.entry_count == 5'd0, "empty result with a head entry")

endmodule
